// ===== hdl/bpq_pkg.sv =====
package bpq_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int IDX_W     = $clog2(MAX_DEPTH);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int HANDLE_W  = 16;
    localparam int PRIO_W    = 16;
    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_PRIO  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_MIN   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]           cmd;
        logic [HANDLE_W-1:0]        part_handle;
        logic signed [PRIO_W-1:0]   priority_value;
        logic [SLOT_W-1:0]          slot_index;
    } item_t;

    typedef struct packed {
        logic                       success;
        logic [HANDLE_W-1:0]        out_handle;
        logic signed [PRIO_W-1:0]   out_priority;
        logic                       is_empty;
        logic                       is_full;
    } result_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]        handle;
        logic signed [PRIO_W-1:0]   prio;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } state_t;

endpackage

// ===== hdl/bpq_ram.sv =====
module bpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/bounded_priority_extract_queue.sv =====
// Bounded queue with priority extract: an ordered store of up to sixteen
// entries, each a part handle with a signed priority.
// An item is taken on a rising edge where start is high and busy is low.
// Every item gives exactly one result, shown on result for one cycle while
// done is high; the receiver cannot stall, so it must take it then.
// A push, or an unused command, gives its result in the cycle after it is
// taken and leaves busy low, so the next item may follow at once.
// The pops and the peek walk the stored entries through a single read port
// of the entry memory, one entry a cycle. A removal then moves each later
// entry down one place, one a cycle through the same port. Busy is high
// throughout the search and the removal.
// The capacity register is written through cfg_valid, cfg_ready and
// cfg_data while the block is idle.
// Reset empties the store and sets the capacity to ten; the memory itself
// is not cleared, as entries beyond the count are never read.
module bounded_priority_extract_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bpq_pkg::item_t                item,
    output logic                          done,
    output bpq_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpq_pkg::CAP_W-1:0]     cfg_data
);

    import bpq_pkg::*;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CAP_W-1:0]       cap_reg;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic signed [PRIO_W-1:0] prio_reg, prio_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   found_reg, found_next;
    entry_t                 best_reg, best_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic                   done_reg, done_next;
    result_t                result_reg, result_next;

    logic                   accept;
    logic                   full_now;
    logic                   push_ok;
    logic                   issue;
    logic                   walk_end;
    logic                   is_pop;
    logic                   hit;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    entry_t                 wr_data;
    logic [IDX_W-1:0]       rd_addr;
    logic [$bits(entry_t)-1:0] rd_raw;
    entry_t                 rd_entry;
    logic                   fin;
    logic [CNT_W-1:0]       fin_count;

    bpq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_entry  = rd_raw;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign result    = result_reg;

    assign accept   = start && !busy;
    assign full_now = (count_reg >= CNT_W'(cap_reg)) || (count_reg >= CNT_W'(MAX_DEPTH));
    assign push_ok  = !full_now && (item.part_handle != '0);
    assign issue    = (scan_reg < count_reg);
    assign walk_end = !issue && !chk_vld_reg;
    assign is_pop   = (cmd_reg == CMD_POP_FRONT) || (cmd_reg == CMD_POP_PRIO)
                   || (cmd_reg == CMD_POP_MIN);
    assign rd_addr  = scan_reg[IDX_W-1:0];

    always_comb
    begin
        case (cmd_reg)
            CMD_POP_FRONT: hit = (chk_idx_reg == '0);
            CMD_POP_PRIO:  hit = !found_reg && (rd_entry.prio == prio_reg);
            CMD_POP_MIN:   hit = !rd_entry.prio[PRIO_W-1]
                              && (!found_reg || (rd_entry.prio < best_reg.prio));
            CMD_PEEK:      hit = (chk_idx_reg == IDX_W'(slot_reg));
            default:       hit = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_POP_FRONT || item.cmd == CMD_POP_PRIO
                               || item.cmd == CMD_POP_MIN || item.cmd == CMD_PEEK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (walk_end)
                begin
                    state_next = (found_reg && is_pop) ? ST_SHIFT : ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (walk_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        prio_next    = prio_reg;
        slot_next    = slot_reg;
        scan_next    = scan_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        pos_next     = pos_reg;
        wr_en        = 1'b0;
        wr_addr      = chk_idx_reg - IDX_W'(1);
        wr_data      = rd_entry;
        fin          = 1'b0;
        fin_count    = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = item.cmd;
                    prio_next  = item.priority_value;
                    slot_next  = item.slot_index;
                    scan_next  = '0;
                    found_next = 1'b0;
                    best_next  = '0;
                    pos_next   = '0;
                    if (item.cmd == CMD_PUSH)
                    begin
                        wr_en          = push_ok;
                        wr_addr        = count_reg[IDX_W-1:0];
                        wr_data.handle = item.part_handle;
                        wr_data.prio   = item.priority_value;
                        found_next     = push_ok;
                        fin            = 1'b1;
                        fin_count      = count_reg + CNT_W'(push_ok);
                    end
                    else if (!(item.cmd == CMD_POP_FRONT || item.cmd == CMD_POP_PRIO
                               || item.cmd == CMD_POP_MIN || item.cmd == CMD_PEEK))
                    begin
                        fin = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    scan_next    = scan_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = scan_reg[IDX_W-1:0];
                end
                if (chk_vld_reg && hit)
                begin
                    found_next = 1'b1;
                    best_next  = rd_entry;
                    pos_next   = chk_idx_reg;
                end
                if (walk_end)
                begin
                    if (found_reg && is_pop)
                    begin
                        scan_next = CNT_W'(pos_reg) + CNT_W'(1);
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (issue)
                begin
                    scan_next    = scan_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = scan_reg[IDX_W-1:0];
                end
                wr_en = chk_vld_reg;
                if (walk_end)
                begin
                    fin       = 1'b1;
                    fin_count = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            count_next = fin_count;
        end
        done_next                = fin;
        result_next              = result_reg;
        if (fin)
        begin
            result_next.success      = found_next;
            result_next.out_handle   = (found_next && state_reg != ST_IDLE)
                                     ? best_reg.handle : '0;
            result_next.out_priority = (found_next && state_reg != ST_IDLE)
                                     ? best_reg.prio : '0;
            result_next.is_empty     = (fin_count == '0);
            result_next.is_full      = (fin_count >= CNT_W'(cap_reg))
                                    || (fin_count >= CNT_W'(MAX_DEPTH));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cap_reg     <= CAP_RESET;
            chk_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        prio_reg    <= prio_next;
        slot_reg    <= slot_next;
        scan_reg    <= scan_next;
        chk_idx_reg <= chk_idx_next;
        found_reg   <= found_next;
        best_reg    <= best_next;
        pos_reg     <= pos_next;
        result_reg  <= result_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DEPTH))
        else $error("Entry count exceeds the store depth.");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SHIFT) || (accept && item.cmd == CMD_PUSH))
        else $error("Entry memory written outside a push or a shift.");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.cmd == CMD_POP_FRONT || item.cmd == CMD_POP_PRIO
                    || item.cmd == CMD_POP_MIN || item.cmd == CMD_PEEK)) |=> busy && !done)
        else $error("Search did not hold the block busy.");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.success) |-> (result.out_handle == '0 && result.out_priority == '0))
        else $error("Unsuccessful result carries an entry.");
`endif

endmodule
